### src/cba_pkg.sv
// Package for the contiguous block allocator: sizes, op and status codes,
// and the controller to datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package cba_pkg;
  localparam int MaxBlocks = 128;
  localparam int BW = $clog2(MaxBlocks);
  localparam int CW = BW + 1;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_RDBLK  = 2'd2;
  localparam logic [1:0] OP_RDDIR  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_BADSIZE  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_RANGE    = 3'd5;

  typedef struct packed {
    logic load;       // latch the request and clear the scan state
    logic scan_step;  // first-fit: look at one block
    logic mark_init;  // point at the first block of the run to free
    logic mark_step;  // write one block of the run
    logic mark_val;   // value written to the free map
    logic find_step;  // delete: compare one entry
    logic shift_step; // move one directory entry down
    logic dir_read;   // read entry at index for op 3
    logic append;     // write new entry at the directory end
    logic dec_count;
    logic set_result; // capture the output beat
    logic [2:0] status;
  } cba_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic size_zero;
    logic dir_full;
    logic scan_done;  // scan reached block count without fit
    logic fit;        // run found at the current block
    logic mark_done;  // last block of run written this step
    logic find_done;  // no more entries to compare
    logic match;
    logic shift_done;
    logic idx_ok;
  } cba_stat_t;
endpackage

### src/contiguous_block_allocator.sv
// Contiguous first-fit block allocator, top level. A create scans the blocks
// and marks the run found, or scans every usable block when there is no room;
// a delete compares entries, shifts each later entry down and frees its run.
// One item at a time, set by the serial block scan and the directory memory
// with one write port; the next beat is taken once the result is accepted.
// Synchronous active-low reset frees every block, empties the directory, sets 128 blocks.
`timescale 1ns / 1ps
module contiguous_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [63:0] file_key, [71:64] size, [78:72] index
  input  logic [79:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [9:3] start_block, [17:10] length, [81:18] entry_key,
  // [82] block_free, [90:83] file_count
  output logic [95:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  cba_pkg::cba_cmd_t  cmd;
  cba_pkg::cba_stat_t stat;
  logic in_fire;
  logic [2:0]  st;
  logic [6:0]  sb;
  logic [7:0]  ln;
  logic [63:0] ek;
  logic        bf;
  logic [7:0]  fc;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  cba_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .stat, .cmd
  );

  cba_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .req_op(in_tuser), .req_key(in_tdata[63:0]),
    .req_size(in_tdata[71:64]), .req_index(in_tdata[78:72]),
    .cfg_we(cfg_valid), .cfg_data,
    .res_status(st), .res_start(sb), .res_length(ln), .res_key(ek),
    .res_free(bf), .res_count(fc)
  );

  assign out_tdata = {5'd0, fc, bf, ek, ln, sb, st};
endmodule

### src/cba_datapath.sv
// Datapath of the contiguous block allocator: free map, directory memory,
// scan and shift counters and the result register. Uses cba_pkg.
`timescale 1ns / 1ps
module cba_datapath (
  input  logic clk,
  input  logic rst_n,
  input  cba_pkg::cba_cmd_t cmd,
  output cba_pkg::cba_stat_t stat,
  input  logic [1:0]  req_op,
  input  logic [63:0] req_key,
  input  logic [7:0]  req_size,
  input  logic [6:0]  req_index,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  output logic [2:0]  res_status,
  output logic [6:0]  res_start,
  output logic [7:0]  res_length,
  output logic [63:0] res_key,
  output logic        res_free,
  output logic [7:0]  res_count
);
  localparam int BW = cba_pkg::BW;
  localparam int CW = cba_pkg::CW;
  localparam int MB = cba_pkg::MaxBlocks;

  logic [MB-1:0] free_r;
  logic [7:0]    blocks_r;
  logic [CW-1:0] used_r;
  logic [1:0]    op_r;
  logic [63:0]   key_r;
  logic [7:0]    size_r;
  logic [6:0]    idx_r;
  logic [CW-1:0] pos_r;   // block or entry pointer
  logic [CW-1:0] run_r;
  logic [BW-1:0] start_r;
  logic [7:0]    len_r;
  logic [63:0]   rkey_r;

  // Directory memory: one write port, one registered read port.
  logic [63:0] mem_key [MB];
  logic [6:0]  mem_st  [MB];
  logic [7:0]  mem_len [MB];
  logic [63:0] rd_key;
  logic [6:0]  rd_st;
  logic [7:0]  rd_len;
  logic [BW-1:0] rd_addr;
  logic        we;
  logic [BW-1:0] wa;
  logic [63:0] wkey;
  logic [6:0]  wst;
  logic [7:0]  wlen;

  logic [CW-1:0] usable;
  logic [CW-1:0] pos_p1;
  assign usable = (blocks_r > 8'(MB)) ? CW'(MB) : CW'(blocks_r);
  assign pos_p1 = pos_r + 1'b1;

  // A compare step fetches the following entry; otherwise the read port
  // holds the entry under the pointer, or the requested one for op 3.
  always_comb begin
    if (cmd.load) rd_addr = (req_op == cba_pkg::OP_RDDIR) ? BW'(req_index) : '0;
    else if (op_r == cba_pkg::OP_RDDIR) rd_addr = idx_r[BW-1:0];
    else if (cmd.find_step) rd_addr = pos_p1[BW-1:0];
    else rd_addr = pos_r[BW-1:0];
  end

  always_comb begin
    we = 1'b0; wa = pos_r[BW-1:0];
    wkey = rd_key; wst = rd_st; wlen = rd_len;
    if (cmd.shift_step) begin
      we = 1'b1;
      wa = BW'(pos_r - 1'b1);
    end else if (cmd.append) begin
      we = 1'b1; wa = used_r[BW-1:0];
      wkey = key_r; wst = 7'(start_r); wlen = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_key[wa] <= wkey;
      mem_st[wa]  <= wst;
      mem_len[wa] <= wlen;
    end
    rd_key <= mem_key[rd_addr];
    rd_st  <= mem_st[rd_addr];
    rd_len <= mem_len[rd_addr];
  end

  assign stat.op         = op_r;
  assign stat.size_zero  = (size_r == 8'd0);
  assign stat.dir_full   = (used_r == CW'(MB));
  assign stat.scan_done  = (pos_r >= usable);
  assign stat.fit        = free_r[pos_r[BW-1:0]] && ({1'b0, run_r} + 1'b1 == {1'b0, size_r});
  assign stat.mark_done  = (len_r <= 8'd1) || (pos_p1 == CW'(MB));
  assign stat.find_done  = (pos_r >= used_r);
  assign stat.match      = (rd_key == key_r);
  assign stat.shift_done = (pos_r >= used_r);
  assign stat.idx_ok     = (op_r == cba_pkg::OP_RDBLK) ? (CW'(idx_r) < usable)
                                                       : (CW'(idx_r) < used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r   <= '1;
      blocks_r <= 8'd128;
      used_r   <= '0;
    end else begin
      if (cfg_we) blocks_r <= cfg_data;
      if (cmd.load) begin
        op_r <= req_op; key_r <= req_key; size_r <= req_size; idx_r <= req_index;
        pos_r <= '0; run_r <= '0;
      end
      if (cmd.scan_step) begin
        if (stat.fit) begin
          start_r <= BW'(pos_p1 - CW'(size_r));
          pos_r   <= CW'(pos_p1 - CW'(size_r));
          len_r   <= size_r;
        end else begin
          run_r <= free_r[pos_r[BW-1:0]] ? run_r + 1'b1 : '0;
          pos_r <= pos_p1;
        end
      end
      if (cmd.mark_init) pos_r <= CW'(start_r);
      if (cmd.mark_step) begin
        free_r[pos_r[BW-1:0]] <= cmd.mark_val;
        pos_r <= pos_p1;
        len_r <= len_r - 1'b1;
      end
      if (cmd.find_step) begin
        if (stat.match) begin
          start_r <= BW'(rd_st);
          len_r   <= rd_len;
          size_r  <= rd_len; // len_r counts down while the run is freed
          rkey_r  <= rd_key;
          pos_r   <= pos_p1; // shift begins with the following entry
        end else begin
          pos_r <= pos_p1;
        end
      end
      if (cmd.shift_step) pos_r <= pos_p1;
      if (cmd.append) used_r <= used_r + 1'b1;
      if (cmd.dec_count) used_r <= used_r - 1'b1;
      if (cmd.dir_read) begin
        start_r <= BW'(rd_st); len_r <= rd_len; rkey_r <= rd_key;
      end
      if (cmd.set_result) begin
        res_status <= cmd.status;
        if (cmd.status != cba_pkg::ST_OK) begin
          res_start <= 7'd0; res_length <= 8'd0; res_key <= 64'd0; res_free <= 1'b0;
          res_count <= 8'(used_r);
        end else begin
          case (op_r)
            cba_pkg::OP_CREATE: begin
              res_start <= 7'(start_r); res_length <= size_r;
              res_key <= 64'd0; res_free <= 1'b0;
              res_count <= 8'(used_r + 1'b1);
            end
            cba_pkg::OP_DELETE: begin
              res_start <= 7'(start_r); res_length <= size_r;
              res_key <= 64'd0; res_free <= 1'b0;
              res_count <= 8'(used_r - 1'b1);
            end
            cba_pkg::OP_RDBLK: begin
              res_start <= 7'd0; res_length <= 8'd0; res_key <= 64'd0;
              res_free <= free_r[idx_r[BW-1:0]];
              res_count <= 8'(used_r);
            end
            default: begin
              res_start <= 7'(start_r); res_length <= len_r; res_key <= rkey_r;
              res_free <= 1'b0;
              res_count <= 8'(used_r);
            end
          endcase
        end
      end
    end
  end
endmodule

### src/cba_ctrl.sv
// Controller of the contiguous block allocator: sequences scan, mark, find
// and shift steps and the output handshake. Uses cba_pkg.
`timescale 1ns / 1ps
module cba_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  cba_pkg::cba_stat_t stat,
  output cba_pkg::cba_cmd_t cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_MARK  = 4'd3;
  localparam logic [3:0] S_FIND  = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_FREE  = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_FWAIT = 4'd10;
  localparam logic [3:0] S_SWAIT = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  // New item waits until the previous result leaves.
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_DISP;
      S_DISP: begin
        case (stat.op)
          cba_pkg::OP_CREATE: begin
            if (stat.size_zero) begin
              cmd.set_result = 1'b1; cmd.status = cba_pkg::ST_BADSIZE; state_nxt = S_OUT;
            end else if (stat.dir_full) begin
              cmd.set_result = 1'b1; cmd.status = cba_pkg::ST_FULL; state_nxt = S_OUT;
            end else state_nxt = S_SCAN;
          end
          cba_pkg::OP_DELETE: state_nxt = S_FIND;
          cba_pkg::OP_RDBLK: begin
            cmd.set_result = 1'b1;
            cmd.status = stat.idx_ok ? cba_pkg::ST_OK : cba_pkg::ST_RANGE;
            state_nxt = S_OUT;
          end
          default: begin
            if (stat.idx_ok) state_nxt = S_READ;
            else begin
              cmd.set_result = 1'b1; cmd.status = cba_pkg::ST_RANGE; state_nxt = S_OUT;
            end
          end
        endcase
      end
      S_READ: begin
        cmd.dir_read = 1'b1; state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.set_result = 1'b1; cmd.status = cba_pkg::ST_OK; state_nxt = S_OUT;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.set_result = 1'b1; cmd.status = cba_pkg::ST_NOSPACE; state_nxt = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.fit) state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        cmd.mark_val = (stat.op == cba_pkg::OP_DELETE);
        if (stat.mark_done) begin
          cmd.set_result = 1'b1; cmd.status = cba_pkg::ST_OK;
          if (stat.op == cba_pkg::OP_DELETE) cmd.dec_count = 1'b1;
          else cmd.append = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_FIND: begin
        if (stat.find_done) begin
          cmd.set_result = 1'b1; cmd.status = cba_pkg::ST_NOTFOUND; state_nxt = S_OUT;
        end else begin
          cmd.find_step = 1'b1;
          if (stat.match) state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: state_nxt = S_SHIFT; // read data for the next entry settles
      S_SHIFT: begin
        if (stat.shift_done) state_nxt = S_FREE;
        else begin
          cmd.shift_step = 1'b1;
          state_nxt = S_SWAIT;
        end
      end
      S_SWAIT: state_nxt = S_SHIFT;
      S_FREE: begin
        cmd.mark_init = 1'b1; state_nxt = S_MARK;
      end
      S_OUT: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule
